/* design/integer_square_root_defines.svh */
// assertion macros shared by the integer square root design
`ifndef INTEGER_SQUARE_ROOT_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define ISR_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ISR_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISR_ASSERT_RST(label, clk, rst_n, prop, msg)
`define ISR_ASSERT(label, clk, prop, msg)
`endif

`endif

/* design/isr_pkg.sv */
package isr_pkg;

  // input bits consumed by one cell, one root bit per cell
  localparam int STEP_BITS = 2;

  // width of the root field on the result channel
  localparam int ROOT_OUT_BITS = 16;

endpackage

/* design/isr_cell.sv */
`include "integer_square_root_defines.svh"

module isr_cell
  import isr_pkg::*;
#(
  parameter int ROOT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     up_valid,
  input  logic [ROOT_BITS+2:0]     up_rem,
  input  logic [ROOT_BITS-1:0]     up_root,
  input  logic [2*ROOT_BITS-1:0]   up_val,
  output logic                     dn_valid,
  output logic [ROOT_BITS+2:0]     dn_rem,
  output logic [ROOT_BITS-1:0]     dn_root,
  output logic [2*ROOT_BITS-1:0]   dn_val
);

  localparam int REM_BITS = ROOT_BITS + 3;
  localparam int VAL_BITS = 2 * ROOT_BITS;

  logic                valid_r;
  logic [REM_BITS-1:0] rem_r, rem_nxt;
  logic [ROOT_BITS-1:0] root_r, root_nxt;
  logic [VAL_BITS-1:0] val_r, val_nxt;

  logic [REM_BITS-1:0] cat;
  logic [REM_BITS-1:0] trial;
  logic                ge;
  logic [ROOT_BITS:0]  root_w;

  // bring down the next pair of input bits and try the next root bit
  always_comb begin
    cat      = {up_rem[REM_BITS-STEP_BITS-1:0], up_val[VAL_BITS-1 -: STEP_BITS]};
    trial    = {1'b0, up_root, 2'b01};
    ge       = (cat >= trial);
    rem_nxt  = ge ? (cat - trial) : cat;
    root_w   = {up_root, ge};
    root_nxt = root_w[ROOT_BITS-1:0];
    val_nxt  = up_val << STEP_BITS;
  end

  // stage register, frozen while the chain is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
    if (adv) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      val_r  <= val_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_root  = root_r;
  assign dn_val   = val_r;

  // remainder never exceeds twice the partial root
  `ISR_ASSERT_RST(a_rem_bound, clk, rst_n, valid_r |-> (rem_r <= {2'b00, root_r, 1'b0}), "cell remainder above twice the partial root")
  // a word moving in is held by the cell next cycle
  `ISR_ASSERT_RST(a_take, clk, rst_n, (adv && up_valid) |=> valid_r, "cell lost a word")
  // a stalled cell keeps its word
  `ISR_ASSERT_RST(a_hold, clk, rst_n, (!adv && valid_r) |=> (valid_r && $stable(root_r)), "stalled cell changed")

endmodule

/* design/integer_square_root.sv */
// channel  ports                          tdata fields (lowest bit up)
// in       in_tvalid in_tready in_tdata   value[INPUT_BITS-1:0]
// out      out_tvalid out_tready out_tdata root[15:0]
//
// a chain of (INPUT_BITS+1)/2 cells, each resolving one root bit from one pair
// of input bits; one word enters per cycle while the chain is not frozen. the
// accepting edge loads the first cell and each edge on which the chain advances
// moves the word one cell on, then from the last cell into the output register,
// which raises out_tvalid.
// rst_n is synchronous and clears the stage valid bits and the output valid bit.
// when the output register holds a word not taken, the whole chain freezes and
// in_tready drops until out_tready frees it.
`include "integer_square_root_defines.svh"

module integer_square_root
  import isr_pkg::*;
#(
  parameter int INPUT_BITS = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((INPUT_BITS+7)/8)*8-1:0]   in_tdata,   // value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ROOT_OUT_BITS-1:0]          out_tdata   // root
);

  localparam int ROOT_BITS = (INPUT_BITS + 1) / 2;
  localparam int VAL_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 3;

  logic                 adv;
  logic [ROOT_BITS:0]   stage_valid;
  logic [REM_BITS-1:0]  stage_rem  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] stage_root [0:ROOT_BITS];
  logic [VAL_BITS-1:0]  stage_val  [0:ROOT_BITS];

  logic                     out_valid_r;
  logic [ROOT_OUT_BITS-1:0] out_root_r, out_root_nxt;

  // chain moves whenever the output register can take a word
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // head of the chain
  assign stage_valid[0] = in_tvalid;
  assign stage_rem[0]   = '0;
  assign stage_root[0]  = '0;
  assign stage_val[0]   = VAL_BITS'(in_tdata[INPUT_BITS-1:0]);

  // one cell per root bit
  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
    isr_cell #(
      .ROOT_BITS(ROOT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .up_valid (stage_valid[i]),
      .up_rem   (stage_rem[i]),
      .up_root  (stage_root[i]),
      .up_val   (stage_val[i]),
      .dn_valid (stage_valid[i+1]),
      .dn_rem   (stage_rem[i+1]),
      .dn_root  (stage_root[i+1]),
      .dn_val   (stage_val[i+1])
    );
  end

  // fit the root into the output field
  if (ROOT_BITS >= ROOT_OUT_BITS) begin : g_trunc
    assign out_root_nxt = stage_root[ROOT_BITS][ROOT_OUT_BITS-1:0];
  end else begin : g_ext
    assign out_root_nxt = ROOT_OUT_BITS'(stage_root[ROOT_BITS]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stage_valid[ROOT_BITS];
    end
    if (adv) begin
      out_root_r <= out_root_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_root_r;

  // a stalled output freezes every cell of the chain
  `ISR_ASSERT_RST(a_chain_frozen, clk, rst_n, !in_tready |=> $stable(stage_valid[ROOT_BITS:1]), "chain moved during a stall")
  // a finished word from the last cell reaches the output register
  `ISR_ASSERT_RST(a_to_out, clk, rst_n, (adv && stage_valid[ROOT_BITS]) |=> out_valid_r, "finished word dropped")
  // reset empties the output register
  `ISR_ASSERT(a_rst_out, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

/* verif/tb_top.sv */
module tb_top;
  import isr_pkg::*;

  localparam int VALUE_BITS = 31;
  localparam int WORD_BITS = ((VALUE_BITS + 7) / 8) * 8;
  localparam int MAX_GAP = 19;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [WORD_BITS-1:0]     word;
    logic [ROOT_OUT_BITS-1:0] root;
  } root_expect_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [WORD_BITS-1:0]     in_tdata;   // value[30:0], bit 31 padding
  logic                     out_tvalid;
  logic                     out_tready;
  logic [ROOT_OUT_BITS-1:0] out_tdata;  // root[15:0]

  root_expect_t pending_roots[$];
  int words_sent;
  int roots_checked;
  int mismatch_count;
  int tx_gap_max;
  int rx_stall_max;
  int hold_cycles;

  integer_square_root #(
    .INPUT_BITS(VALUE_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // floor root, one root bit per pair of value bits, padding bit dropped
  function automatic logic [ROOT_OUT_BITS-1:0] floor_root(input logic [WORD_BITS-1:0] word);
    logic [WORD_BITS-1:0] value;
    logic [33:0]          rem;
    logic [33:0]          trial;
    logic [16:0]          root;
    value = {1'b0, word[VALUE_BITS-1:0]};
    rem = '0;
    root = '0;
    for (int i = 15; i >= 0; i--) begin
      rem = (rem << 2) | 34'((value >> (2 * i)) & 32'd3);
      trial = (34'(root) << 2) | 34'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 17'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[ROOT_OUT_BITS-1:0];
  endfunction

  // offer one word after a random gap, hold it until taken
  task automatic send_word(input logic [WORD_BITS-1:0] word);
    int gap;
    root_expect_t entry;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    entry.word = word;
    entry.root = floor_root(word);
    pending_roots.push_back(entry);
    words_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_for_roots();
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  // mixed value shapes: full range, around squares, small, random length
  function automatic logic [WORD_BITS-1:0] pick_value();
    logic [WORD_BITS-1:0] v;
    logic [WORD_BITS-1:0] r;
    int shape;
    shape = $urandom_range(0, 5);
    case (shape)
      0: v = $urandom;
      1, 2: begin
        r = $urandom_range(0, 46340);
        v = r * r;
        case ($urandom_range(0, 2))
          0: if (v != 0) v = v - 1;
          2: v = v + 1;
          default: ;
        endcase
        if (v > 32'h7FFF_FFFF) v = 32'h7FFF_FFFF;
      end
      3: v = $urandom_range(0, 1023);
      4: v = $urandom >> $urandom_range(1, 31);
      default: v = $urandom & 32'h7FFF_FFFF;
    endcase
    // padding bit must be ignored
    if (shape != 0 && $urandom_range(0, 7) == 0) v[WORD_BITS-1] = 1'b1;
    return v;
  endfunction

  task automatic test_corners();
    logic [WORD_BITS-1:0] corners[$];
    corners = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd15, 32'd16,
                32'd24, 32'd25, 32'd99, 32'd100, 32'h3FFF_FFFF, 32'h4000_0000,
                32'h5555_5555, 32'h2AAA_AAAA, 32'd2147395599, 32'd2147395600,
                32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0019};
    foreach (corners[i]) send_word(corners[i]);
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_full_stall();
    tx_gap_max = 0;
    hold_cycles = 200;
    repeat (40) send_word(pick_value());
    tx_gap_max = MAX_GAP;
  endtask

  // sender pauses until the pipeline has drained completely
  task automatic test_drain_pause();
    release_input();
    wait_for_roots();
    repeat (20) send_word(pick_value());
  endtask

  // random values, idling regime changes every hundred words
  task automatic test_random_values();
    for (int n = 0; n < 1870; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: begin tx_gap_max = 0; rx_stall_max = 0; end
          1: begin tx_gap_max = MAX_GAP; rx_stall_max = 0; end
          2: begin tx_gap_max = 0; rx_stall_max = MAX_GAP; end
          default: begin tx_gap_max = MAX_GAP; rx_stall_max = MAX_GAP; end
        endcase
      end
      send_word(pick_value());
    end
    tx_gap_max = MAX_GAP;
    rx_stall_max = MAX_GAP;
  endtask

  // receiver: random stall per word, plus long hold-off on request
  initial begin
    int stall;
    int held;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        held = hold_cycles;
        hold_cycles = 0;
        repeat (held) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      stall = $urandom_range(0, rx_stall_max);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic note_mismatch(input string what, input root_expect_t head);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: word %h expected root %0d actual root %0d",
               what, head.word, head.root, out_tdata);
  endtask

  // compare each root taken against the oldest expected one
  always @(posedge clk) begin : check_root
    root_expect_t head;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_roots.size() == 0) begin
        head.word = 'x;
        head.root = 'x;
        note_mismatch("unexpected word", head);
      end else begin
        head = pending_roots.pop_front();
        roots_checked++;
        if (out_tdata !== head.root) note_mismatch("root", head);
      end
    end
  end

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    words_sent = 0;
    roots_checked = 0;
    mismatch_count = 0;
    tx_gap_max = MAX_GAP;
    rx_stall_max = MAX_GAP;
    hold_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corners();
    test_full_stall();
    test_drain_pause();
    test_random_values();
    release_input();

    for (int n = 0; n < 5000 && pending_roots.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_roots.size() != 0) begin
      $display("%0d roots never arrived", pending_roots.size());
      mismatch_count += pending_roots.size();
    end

    $display("%0d words sent, %0d roots checked, %0d mismatches", words_sent,
             roots_checked, mismatch_count);
    $display("covered corner values, padding bit, full pipeline stall, drain pause");
    if (mismatch_count == 0) begin
      $display("integer_square_root regression: pass");
    end else begin
      $display("integer_square_root regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d roots outstanding", pending_roots.size());
    $display("integer_square_root regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/isr_pkg.sv
design/isr_cell.sv
design/integer_square_root.sv
verif/tb_top.sv
